// ===== src/dvrt_pkg.sv =====
// package: types, constants and helpers for the distance-vector route table
`default_nettype none
package dvrt_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

   localparam logic [2:0] FL_DIRECT = 3'd1;
   localparam logic [2:0] FL_ROUTER = 3'd2;
   localparam logic [2:0] FL_NET    = 3'd4;

   typedef enum logic [2:0] {
      ST_IGNORED   = 3'd0,
      ST_CHANGED   = 3'd1,
      ST_INSERTED  = 3'd2,
      ST_UNCHANGED = 3'd3,
      ST_FULL      = 3'd4,
      ST_READ      = 3'd5,
      ST_EMPTY     = 3'd6,
      ST_SWEEP     = 3'd7
   } status_type;

   typedef enum logic [1:0] {
      MODE_LOAD   = 2'd0,
      MODE_VECTOR = 2'd1,
      MODE_SWEEP  = 2'd2,
      MODE_READ   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      CSR_INFINITY = 2'd0,
      CSR_HOLD     = 2'd1,
      CSR_TIMEOUT  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [31:0] turn;
      logic [31:0] sender_addr;
      logic [31:0] network_addr;
      logic [5:0]  prefix_len;
      logic [31:0] distance;
      logic [5:0]  entry_index;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] out_network;
      logic [5:0]  out_prefix;
      logic [31:0] out_distance;
      logic [31:0] out_direct_distance;
      logic [31:0] out_next_hop;
      logic        out_is_direct;
      logic        out_router_live;
      logic        out_network_live;
      logic [31:0] out_last_seen;
      logic [6:0]  deleted_count;
   } rsp_type;

   // one stored route
   typedef struct packed {
      logic [31:0] network;
      logic [5:0]  prefix;
      logic [31:0] next_hop;
      logic [31:0] distance;
      logic [31:0] direct_distance;
      logic [31:0] heard_turn;
      logic [2:0]  flags;
   } entry_type;

   // memory port bundle between the sequencer and the store
   typedef struct packed {
      logic              rd_en;
      logic [IDX_W-1:0]  rd_addr;
      logic              wr_en;
      logic [IDX_W-1:0]  wr_addr;
      entry_type         wr_data;
   } mem_req_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FIND_RD,
      S_FIND_CHK,
      S_SND_WR,
      S_MATCH_RD,
      S_MATCH_CHK,
      S_SW_RD,
      S_SW_CHK,
      S_POI_RD,
      S_POI_CHK,
      S_SH_RD,
      S_SH_WR,
      S_READ_RD,
      S_READ_OUT,
      S_DONE
   } state_type;

   function automatic logic [31:0] bcast(input logic [31:0] net, input logic [5:0] p);
      logic [31:0] m;
      m = 32'hFFFF_FFFF;
      if (p == 6'd0) begin
         bcast = 32'hFFFF_FFFF;
      end else if (p >= 6'd32) begin
         bcast = net;
      end else begin
         m = m >> p;
         bcast = net | m;
      end
   endfunction

endpackage
`default_nettype wire

// ===== src/distance_vector_route_table.sv =====
// top level: distance-vector route table with configuration registers
//  channel  | handshake          | payload
//  request  | start / busy       | req_item
//  result   | rsp_strobe         | rsp_item
//  config   | csr_write_enable   | csr_index, csr_write_data
// vector entry: two scans of the used slots (sender, then network), each slot read then checked
// sweep: one slot pass plus a poison pass per timed-out neighbour and a shift pass per deletion
// load goes to S_DONE, read via S_READ_RD, S_READ_OUT if used; strobe falls the cycle after busy
// synchronous reset empties the table at once through the used count
// the result receiver cannot stall; a result is shown for one cycle only
`default_nettype none
module distance_vector_route_table (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire dvrt_pkg::req_type req_item,
   output logic                   rsp_strobe,
   output dvrt_pkg::rsp_type      rsp_item,
   input  wire logic              csr_write_enable,
   input  wire logic [1:0]        csr_index,
   input  wire logic [31:0]       csr_write_data
);
   import dvrt_pkg::*;

   logic [31:0] inf_ff;
   logic [15:0] hold_ff, tout_ff;
   mem_req_type mreq;
   entry_type rd_data;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         inf_ff <= 32'd16;
         hold_ff <= 16'd3;
         tout_ff <= 16'd5;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_INFINITY: inf_ff <= csr_write_data;
            CSR_HOLD:     hold_ff <= csr_write_data[15:0];
            CSR_TIMEOUT:  tout_ff <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   dvrt_seq u_seq (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req_item),
      .inf_d(inf_ff), .hold_t(hold_ff), .tout_t(tout_ff), .mreq(mreq),
      .rd_data(rd_data), .rsp_strobe(rsp_strobe), .rsp(rsp_item)
   );

   dvrt_store u_store (.clock(clock), .mreq(mreq), .rd_data(rd_data));
endmodule
`default_nettype wire

// ===== src/dvrt_store.sv =====
// route entry memory: one write and one registered read port
`default_nettype none
module dvrt_store (
   input  wire logic                clock,
   input  wire dvrt_pkg::mem_req_type mreq,
   output dvrt_pkg::entry_type      rd_data
);
   import dvrt_pkg::*;

   entry_type mem_ff [TABLE_ENTRIES];

   // write port
   always_ff @(posedge clock) begin
      if (mreq.wr_en) begin
         mem_ff[mreq.wr_addr] <= mreq.wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (mreq.rd_en) begin
         rd_data <= mem_ff[mreq.rd_addr];
      end
   end
endmodule
`default_nettype wire

// ===== src/dvrt_seq.sv =====
// sequencer: walks the table slot by slot for vector and sweep operations
`default_nettype none
module dvrt_seq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire dvrt_pkg::req_type    req,
   input  wire logic [31:0]          inf_d,
   input  wire logic [15:0]          hold_t,
   input  wire logic [15:0]          tout_t,
   output dvrt_pkg::mem_req_type     mreq,
   input  wire dvrt_pkg::entry_type  rd_data,
   output logic                      rsp_strobe,
   output dvrt_pkg::rsp_type         rsp
);
   import dvrt_pkg::*;

   state_type state_ff, state_in;
   req_type req_ff, req_in;
   logic [CNT_W-1:0] n_ff, n_in;       // used count
   logic [CNT_W-1:0] i_ff, i_in;       // walk index
   logic [CNT_W-1:0] k_ff, k_in;       // inner index
   logic [CNT_W-1:0] s_ff, s_in;       // sender slot
   entry_type snd_ff, snd_in;          // sender entry after update
   entry_type cur_ff, cur_in;          // entry under sweep
   logic held_ff, held_in;
   logic [31:0] sum_ff, sum_in;
   logic [6:0] del_ff, del_in;
   rsp_type rsp_ff, rsp_in;
   logic strobe_ff, strobe_in;

   logic [32:0] raw_sum;
   logic [31:0] age;
   logic [31:0] want;
   entry_type e;

   assign busy = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         n_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff <= n_in;
         strobe_ff <= strobe_in;
      end
      req_ff <= req_in;
      i_ff <= i_in;
      k_ff <= k_in;
      s_ff <= s_in;
      snd_ff <= snd_in;
      cur_ff <= cur_in;
      held_ff <= held_in;
      sum_ff <= sum_in;
      del_ff <= del_in;
      rsp_ff <= rsp_in;
   end

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      n_in = n_ff;
      i_in = i_ff;
      k_in = k_ff;
      s_in = s_ff;
      snd_in = snd_ff;
      cur_in = cur_ff;
      held_in = held_ff;
      sum_in = sum_ff;
      del_in = del_ff;
      rsp_in = rsp_ff;
      strobe_in = 1'b0;
      mreq = '0;
      e = rd_data;
      raw_sum = 33'd0;
      age = req_ff.turn - rd_data.heard_turn;
      want = bcast(req_ff.network_addr, req_ff.prefix_len);
      case (state_ff)
         S_IDLE: begin
            rsp_in = '0;
            del_in = '0;
            held_in = 1'b0;
            i_in = '0;
            if (start) begin
               req_in = req;
               case (mode_type'(req.mode))
                  MODE_LOAD: begin
                     if (n_ff >= CNT_W'(TABLE_ENTRIES)) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        mreq.wr_en = 1'b1;
                        mreq.wr_addr = n_ff[IDX_W-1:0];
                        mreq.wr_data = '{req.network_addr, req.prefix_len, req.network_addr,
                           req.distance, req.distance, req.turn,
                           FL_DIRECT | FL_ROUTER | FL_NET};
                        n_in = n_ff + 1'b1;
                        rsp_in.status = ST_INSERTED;
                     end
                     state_in = S_DONE;
                  end
                  MODE_VECTOR: state_in = S_FIND_RD;
                  MODE_SWEEP:  state_in = S_SW_RD;
                  default:     state_in = S_READ_RD;
               endcase
            end
         end
         // search the sender
         S_FIND_RD: begin
            if (i_ff >= n_ff) begin
               rsp_in.status = ST_IGNORED;
               state_in = S_DONE;
            end else begin
               mreq.rd_en = 1'b1;
               mreq.rd_addr = i_ff[IDX_W-1:0];
               state_in = S_FIND_CHK;
            end
         end
         S_FIND_CHK: begin
            if (rd_data.network == req_ff.sender_addr) begin
               e.flags = rd_data.flags | FL_ROUTER | FL_NET;
               e.heard_turn = req_ff.turn;
               if (rd_data.direct_distance < rd_data.distance) begin
                  e.distance = rd_data.direct_distance;
               end
               snd_in = e;
               s_in = i_ff;
               raw_sum = {1'b0, rd_data.direct_distance} + {1'b0, req_ff.distance};
               sum_in = (raw_sum > {1'b0, inf_d}) ? inf_d : raw_sum[31:0];
               state_in = S_SND_WR;
            end else begin
               i_in = i_ff + 1'b1;
               state_in = S_FIND_RD;
            end
         end
         S_SND_WR: begin
            mreq.wr_en = 1'b1;
            mreq.wr_addr = s_ff[IDX_W-1:0];
            mreq.wr_data = snd_ff;
            i_in = '0;
            state_in = S_MATCH_RD;
         end
         // search the advertised network
         S_MATCH_RD: begin
            if (i_ff >= n_ff) begin
               if (held_ff) begin
                  rsp_in.status = ST_UNCHANGED;
               end else if (n_ff >= CNT_W'(TABLE_ENTRIES)) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  mreq.wr_en = 1'b1;
                  mreq.wr_addr = n_ff[IDX_W-1:0];
                  mreq.wr_data = '{req_ff.network_addr, req_ff.prefix_len,
                     req_ff.sender_addr, sum_ff, inf_d, req_ff.turn, FL_NET};
                  n_in = n_ff + 1'b1;
                  rsp_in.status = ST_INSERTED;
               end
               state_in = S_DONE;
            end else begin
               mreq.rd_en = 1'b1;
               mreq.rd_addr = i_ff[IDX_W-1:0];
               state_in = S_MATCH_CHK;
            end
         end
         S_MATCH_CHK: begin
            i_in = i_ff + 1'b1;
            state_in = S_MATCH_RD;
            if (bcast(rd_data.network, rd_data.prefix) == want) begin
               if (rd_data.flags[0] && !rd_data.flags[1] && age < {16'd0, hold_t}) begin
                  held_in = 1'b1;
               end else begin
                  state_in = S_DONE;
                  if (req_ff.distance >= inf_d && rd_data.next_hop == snd_ff.network) begin
                     e.distance = inf_d;
                     e.heard_turn = req_ff.turn;
                     mreq.wr_en = 1'b1;
                     rsp_in.status = ST_CHANGED;
                  end else if (rd_data.distance > sum_ff) begin
                     e.distance = sum_ff;
                     e.next_hop = snd_ff.network;
                     mreq.wr_en = 1'b1;
                     rsp_in.status = ST_CHANGED;
                  end else begin
                     rsp_in.status = ST_UNCHANGED;
                  end
                  mreq.wr_addr = i_ff[IDX_W-1:0];
                  mreq.wr_data = e;
               end
            end
         end
         // age sweep
         S_SW_RD: begin
            if (i_ff >= n_ff) begin
               rsp_in.status = ST_SWEEP;
               rsp_in.deleted_count = del_ff;
               state_in = S_DONE;
            end else begin
               mreq.rd_en = 1'b1;
               mreq.rd_addr = i_ff[IDX_W-1:0];
               state_in = S_SW_CHK;
            end
         end
         S_SW_CHK: begin
            cur_in = rd_data;
            state_in = S_SW_RD;
            i_in = i_ff + 1'b1;
            if (rd_data.flags[0]) begin
               if (rd_data.flags[2] && age > {16'd0, tout_t}) begin
                  e.flags = rd_data.flags & ~FL_ROUTER;
                  e.distance = inf_d;
                  if (rd_data.flags[1]) begin
                     e.heard_turn = req_ff.turn;
                     k_in = '0;
                     i_in = i_ff;
                     state_in = S_POI_RD;
                  end
                  mreq.wr_en = 1'b1;
                  mreq.wr_addr = i_ff[IDX_W-1:0];
                  mreq.wr_data = e;
                  cur_in = e;
               end
            end else if (rd_data.distance >= inf_d && age > {16'd0, hold_t}) begin
               del_in = del_ff + 1'b1;
               k_in = i_ff;
               i_in = i_ff;
               state_in = S_SH_RD;
            end
         end
         // poison routes through a timed-out neighbour
         S_POI_RD: begin
            if (k_ff >= n_ff) begin
               i_in = i_ff + 1'b1;
               state_in = S_SW_RD;
            end else begin
               mreq.rd_en = 1'b1;
               mreq.rd_addr = k_ff[IDX_W-1:0];
               state_in = S_POI_CHK;
            end
         end
         S_POI_CHK: begin
            if (rd_data.next_hop == cur_ff.network) begin
               e.distance = inf_d;
               e.heard_turn = req_ff.turn;
               mreq.wr_en = 1'b1;
               mreq.wr_addr = k_ff[IDX_W-1:0];
               mreq.wr_data = e;
            end
            k_in = k_ff + 1'b1;
            state_in = S_POI_RD;
         end
         // move later entries down by one
         S_SH_RD: begin
            if (k_ff + 1'b1 >= n_ff) begin
               n_in = n_ff - 1'b1;
               state_in = S_SW_RD;
            end else begin
               mreq.rd_en = 1'b1;
               mreq.rd_addr = IDX_W'(k_ff + 1'b1);
               state_in = S_SH_WR;
            end
         end
         S_SH_WR: begin
            mreq.wr_en = 1'b1;
            mreq.wr_addr = k_ff[IDX_W-1:0];
            mreq.wr_data = rd_data;
            k_in = k_ff + 1'b1;
            state_in = S_SH_RD;
         end
         // slot read
         S_READ_RD: begin
            if ({1'b0, req_ff.entry_index} >= (IDX_W+1)'(TABLE_ENTRIES) ||
                CNT_W'(req_ff.entry_index) >= n_ff) begin
               rsp_in.status = ST_EMPTY;
               state_in = S_DONE;
            end else begin
               mreq.rd_en = 1'b1;
               mreq.rd_addr = req_ff.entry_index[IDX_W-1:0];
               state_in = S_READ_OUT;
            end
         end
         S_READ_OUT: begin
            rsp_in.status = ST_READ;
            rsp_in.out_network = rd_data.network;
            rsp_in.out_prefix = rd_data.prefix;
            rsp_in.out_distance = rd_data.distance;
            rsp_in.out_direct_distance = rd_data.direct_distance;
            rsp_in.out_next_hop = rd_data.next_hop;
            rsp_in.out_is_direct = rd_data.flags[0];
            rsp_in.out_router_live = rd_data.flags[1];
            rsp_in.out_network_live = rd_data.flags[2];
            rsp_in.out_last_seen = rd_data.heard_turn;
            state_in = S_DONE;
         end
         S_DONE: begin
            strobe_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire
